[hdl/ncdf_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the exponential table of the normal CDF unit.
package ncdf_pkg;

	localparam int EXP_TABLE_BITS = 10;
	localparam int EXP_SIZE = 1 << EXP_TABLE_BITS;
	localparam int DIV_STAGES = 32;
	localparam int EXP_STEPS = 21;
	localparam int HORNER_STEPS = 5;

	localparam logic [18:0] Q196 = 19'd128451;
	localparam logic [18:0] Q392 = 19'd256902;
	localparam logic [16:0] P_ONE = 17'd65536;
	localparam logic [16:0] P_HALF = 17'd32768;
	localparam logic [29:0] SQRT_HALF = 30'd759250125;
	localparam logic [28:0] CP = 29'd351748265;
	localparam logic [28:0] EXP_M1 = 29'd395007542;
	localparam logic [19:0] U_CLAMP = 20'd524288;
	localparam logic signed [33:0] CA5 = 34'sd1139675401;
	localparam logic signed [33:0] HORNER_C [HORNER_STEPS] = '{
		-34'sd1560310108, 34'sd1526231383, -34'sd305476044, 34'sd273621191, 34'sd0
	};

	typedef enum logic [1:0] {
		MODE_STD = 2'd0,
		MODE_SCALED = 2'd1,
		MODE_ONE_SIDED = 2'd2,
		MODE_TWO_SIDED = 2'd3
	} ncdf_mode_t;

	typedef enum logic [3:0] {
		REG_MODE = 4'd0,
		REG_DEFAULT = 4'd1
	} ncdf_reg_t;

	typedef struct packed {
		ncdf_mode_t mode;
		logic fb;
		logic [16:0] fbp;
	} ncdf_meta_t;

	typedef struct packed {
		ncdf_meta_t meta;
		logic neg;
		logic ovf;
		logic [30:0] e;
	} ncdf_tag_t;

	typedef logic [30:0] ncdf_exp_rom_t [EXP_SIZE];

	// Restoring long division used while the table is built.
	function automatic longint unsigned udiv_small(longint unsigned num, int unsigned dv);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = (r << 1) | ((num >> b) & 64'd1);
			if (r >= longint'(dv)) begin
				r = r - longint'(dv);
				q = q | (64'd1 << b);
			end
		end
		return q;
	endfunction

	// Entry k holds exp(-k / EXP_SIZE) in Q1.30 from a truncated Taylor sum.
	function automatic ncdf_exp_rom_t build_exp_rom();
		ncdf_exp_rom_t rom;
		longint unsigned f;
		longint unsigned term;
		longint sum;
		for (int k = 0; k < EXP_SIZE; k++) begin
			f = longint'(k) << (30 - EXP_TABLE_BITS);
			term = 64'd1 << 30;
			sum = 64'sd1 << 30;
			for (int n = 1; n <= 16; n++) begin
				term = udiv_small((term * f) >> 30, 32'(n));
				if ((n & 1) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			rom[k] = (sum < 0) ? 31'd0 : 31'(sum);
		end
		return rom;
	endfunction

	localparam ncdf_exp_rom_t EXP_ROM = build_exp_rom();

endpackage

[hdl/ncdf_if.sv]
`timescale 1ns / 1ps
// Channel interfaces of the normal CDF unit: samples, results and register writes.
interface ncdf_sample_if;
	logic valid;
	logic ready;
	logic signed [31:0] value_x;
	logic signed [31:0] lower_or_mean;
	logic signed [31:0] upper_or_sigma;
	modport source(output valid, value_x, lower_or_mean, upper_or_sigma, input ready);
	modport sink(input valid, value_x, lower_or_mean, upper_or_sigma, output ready);
endinterface

interface ncdf_result_if;
	logic valid;
	logic ready;
	logic [16:0] probability;
	logic fallback_used;
	modport source(output valid, probability, fallback_used, input ready);
	modport sink(input valid, probability, fallback_used, output ready);
endinterface

interface ncdf_cfg_if;
	logic valid;
	logic ready;
	logic [3:0] index;
	logic [16:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hdl/ncdf_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
module ncdf_div (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [63:0] num,
	input logic [32:0] den,
	input ncdf_pkg::ncdf_tag_t tag_in,
	output logic out_valid,
	output logic [31:0] quo,
	output ncdf_pkg::ncdf_tag_t tag_out
);

	localparam int N = ncdf_pkg::DIV_STAGES;

	// The upper half of the dividend must be below the divisor on entry.
	logic v_s [0:N];
	logic [31:0] quo_s [0:N];
	ncdf_pkg::ncdf_tag_t tag_s [0:N];
	logic [32:0] rem_s [0:N-1];
	logic [31:0] low_s [0:N-1];
	logic [32:0] den_s [0:N-1];

	assign v_s[0] = in_valid;
	assign quo_s[0] = '0;
	assign tag_s[0] = tag_in;
	assign rem_s[0] = {1'b0, num[63:32]};
	assign low_s[0] = num[31:0];
	assign den_s[0] = den;

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [33:0] trial;
		logic fits;

		assign trial = {rem_s[i], low_s[i][31]};
		assign fits = trial >= {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i+1] <= {quo_s[i][30:0], fits};
				tag_s[i+1] <= tag_s[i];
			end
		end

		if (i < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1] <= fits ? 33'(trial - {1'b0, den_s[i]}) : trial[32:0];
					low_s[i+1] <= {low_s[i][30:0], 1'b0};
					den_s[i+1] <= den_s[i];
				end
			end
		end
	end

	assign out_valid = v_s[N];
	assign quo = quo_s[N];
	assign tag_out = tag_s[N];

endmodule

[hdl/normal_cdf_pvalue_unit.sv]
`timescale 1ns / 1ps
// Top level of the normal CDF and p-value unit.
//
// Samples arrive on the sample channel as three signed Q16.16 words, and each
// sample yields one beat on the result channel: a Q1.16 probability and a
// fallback flag. The mode and default probability registers are written over
// the cfg channel, which is always ready; write them only while no sample is
// in flight.
// The unit is a 99-stage pipeline that accepts one sample in every cycle while
// the receiver does not stall. Most of the stages are the two 32-stage dividers
// (standard score and 1/(1+p*u)), the 21 stages of repeated exp(-1) scaling
// and the five Horner stages.
// Reset clears all valid bits and loads mode 3 and a default of 1.0.
// When the receiver stalls with a result waiting, the pipeline holds every
// stage and the sample channel drops ready; nothing is lost or repeated.
module normal_cdf_pvalue_unit (
	input logic clk,
	input logic arst_n,
	ncdf_sample_if.sink sample,
	ncdf_result_if.source result,
	ncdf_cfg_if.sink cfg
);

	localparam int ES = ncdf_pkg::EXP_STEPS;
	localparam int HS = ncdf_pkg::HORNER_STEPS;
	localparam int EB = ncdf_pkg::EXP_TABLE_BITS;

	function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
		input logic [30:0] t);
		logic [33:0] m;
		logic [64:0] p;
		logic signed [33:0] r;
		m = a[33] ? 34'(-a) : 34'(a);
		p = 65'(m) * 65'(t);
		r = $signed(34'(p >> 30));
		return a[33] ? -r : r;
	endfunction

	logic en;
	ncdf_pkg::ncdf_mode_t mode_q;
	logic [16:0] dflt_q;

	assign en = !result.valid || result.ready;
	assign sample.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ncdf_pkg::MODE_TWO_SIDED;
			dflt_q <= ncdf_pkg::P_ONE;
		end else if (cfg.valid) begin
			unique case (ncdf_pkg::ncdf_reg_t'(cfg.index))
				ncdf_pkg::REG_MODE: mode_q <= ncdf_pkg::ncdf_mode_t'(cfg.data[1:0]);
				ncdf_pkg::REG_DEFAULT: dflt_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Stage 1: numerator and divisor of the standard score.
	logic signed [32:0] diff, span;
	logic signed [33:0] mul_a;
	logic [18:0] mul_k;
	logic signed [53:0] mul_p;
	logic signed [53:0] num_c;
	logic signed [33:0] den_c;
	ncdf_pkg::ncdf_meta_t meta_c;
	logic v_s1;
	ncdf_pkg::ncdf_meta_t meta_s1;
	logic signed [53:0] num_s1;
	logic signed [33:0] den_s1;

	assign diff = {sample.value_x[31], sample.value_x}
		- {sample.lower_or_mean[31], sample.lower_or_mean};
	assign span = {sample.upper_or_sigma[31], sample.upper_or_sigma}
		- {sample.lower_or_mean[31], sample.lower_or_mean};
	assign mul_a = (mode_q == ncdf_pkg::MODE_ONE_SIDED)
		? {{2{sample.value_x[31]}}, sample.value_x} : {diff[32], diff};
	assign mul_k = (mode_q == ncdf_pkg::MODE_ONE_SIDED) ? ncdf_pkg::Q196 : ncdf_pkg::Q392;
	assign mul_p = mul_a * $signed({1'b0, mul_k});

	always_comb begin
		meta_c.mode = mode_q;
		meta_c.fb = mode_q[1] && (span <= 33'sd0);
		meta_c.fbp = (dflt_q > ncdf_pkg::P_ONE) ? ncdf_pkg::P_ONE : dflt_q;
		num_c = mul_p;
		den_c = meta_c.fb ? 34'sd1 : {span[32], span};
		case (mode_q)
			ncdf_pkg::MODE_STD: begin
				num_c = {{22{sample.value_x[31]}}, sample.value_x};
				den_c = 34'sd1;
			end
			ncdf_pkg::MODE_SCALED: begin
				num_c = {{5{diff[32]}}, diff, 16'd0};
				den_c = (sample.upper_or_sigma == 32'sd0) ? 34'sd65536
					: {{2{sample.upper_or_sigma[31]}}, sample.upper_or_sigma};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= meta_c;
			num_s1 <= num_c;
			den_s1 <= den_c;
		end
	end

	// Stage 2: magnitudes, quotient sign and overflow of the score division.
	logic [53:0] nmag;
	logic [32:0] dmag;
	logic ovf_c;
	logic v_s2;
	logic [63:0] num_s2;
	logic [32:0] den_s2;
	ncdf_pkg::ncdf_tag_t tag_s2;

	assign nmag = num_s1[53] ? 54'(-num_s1) : 54'(num_s1);
	assign dmag = den_s1[33] ? 33'(-den_s1) : 33'(den_s1);
	assign ovf_c = 33'(nmag[53:32]) >= dmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= ovf_c ? 64'd0 : 64'(nmag);
			den_s2 <= dmag;
			tag_s2 <= '{meta: meta_s1, neg: num_s1[53] ^ den_s1[33], ovf: ovf_c, e: '0};
		end
	end

	logic v_d1;
	logic [31:0] quo1;
	ncdf_pkg::ncdf_tag_t tag_d1;

	ncdf_div u_div_score (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s2),
		.num(num_s2),
		.den(den_s2),
		.tag_in(tag_s2),
		.out_valid(v_d1),
		.quo(quo1),
		.tag_out(tag_d1)
	);

	// Stage 3: signed, offset and saturated standard score.
	logic signed [34:0] zq;
	logic signed [31:0] z_c;
	logic v_s3;
	ncdf_pkg::ncdf_meta_t meta_s3;
	logic signed [31:0] z_s3;

	always_comb begin
		zq = tag_d1.neg ? -$signed({3'b000, quo1}) : $signed({3'b000, quo1});
		if (tag_d1.meta.mode == ncdf_pkg::MODE_TWO_SIDED) begin
			zq = zq - 35'sd128451;
		end
		if (tag_d1.ovf) begin
			z_c = tag_d1.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else if (zq > 35'sd2147483647) begin
			z_c = 32'sh7fff_ffff;
		end else if (zq < -35'sd2147483648) begin
			z_c = 32'sh8000_0000;
		end else begin
			z_c = zq[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s3 <= tag_d1.meta;
			z_s3 <= z_c;
		end
	end

	// Stage 4: magnitude of the score.
	logic v_s4;
	ncdf_pkg::ncdf_meta_t meta_s4;
	logic neg_s4;
	logic [31:0] mag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s4 <= meta_s3;
			neg_s4 <= z_s3[31];
			mag_s4 <= z_s3[31] ? 32'(-z_s3) : 32'(z_s3);
		end
	end

	// Stage 5: u = |z| / sqrt(2), clamped.
	logic [61:0] uprod;
	logic [31:0] ushift;
	logic v_s5;
	ncdf_pkg::ncdf_meta_t meta_s5;
	logic neg_s5;
	logic [19:0] u_s5;

	assign uprod = 62'(mag_s4) * 62'(ncdf_pkg::SQRT_HALF);
	assign ushift = uprod[61:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s5 <= meta_s4;
			neg_s5 <= neg_s4;
			u_s5 <= (ushift > 32'(ncdf_pkg::U_CLAMP)) ? ncdf_pkg::U_CLAMP : ushift[19:0];
		end
	end

	// Stage 6: divisor 1 + p*u and the square w = u*u.
	logic [48:0] cpu;
	logic [39:0] uu;
	logic v_s6;
	ncdf_pkg::ncdf_meta_t meta_s6;
	logic neg_s6;
	logic [31:0] den2_s6;
	logic [22:0] w_s6;

	assign cpu = 49'(u_s5) * 49'(ncdf_pkg::CP);
	assign uu = 40'(u_s5) * 40'(u_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s6 <= meta_s5;
			neg_s6 <= neg_s5;
			den2_s6 <= 32'h4000_0000 + 32'(cpu[48:16]);
			w_s6 <= uu[38:16];
		end
	end

	// Stage 7 and the exp chain: table read, then at most one exp(-1) step per stage.
	logic exp_v_s [0:ES];
	logic [30:0] exp_e_s [0:ES];
	logic [4:0] exp_n_s [0:ES-1];
	logic [31:0] exp_den_s [0:ES];
	logic exp_neg_s [0:ES];
	ncdf_pkg::ncdf_meta_t exp_meta_s [0:ES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_v_s[0] <= 1'b0;
		end else if (en) begin
			exp_v_s[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			exp_e_s[0] <= ncdf_pkg::EXP_ROM[w_s6[15 -: EB]];
			exp_n_s[0] <= (w_s6[22:16] > 7'(ES)) ? 5'(ES) : w_s6[20:16];
			exp_den_s[0] <= den2_s6;
			exp_neg_s[0] <= neg_s6;
			exp_meta_s[0] <= meta_s6;
		end
	end

	for (genvar i = 0; i < ES; i++) begin : g_exp
		logic [60:0] ep;

		assign ep = 61'(exp_e_s[i]) * 61'(ncdf_pkg::EXP_M1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				exp_v_s[i+1] <= 1'b0;
			end else if (en) begin
				exp_v_s[i+1] <= exp_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				exp_e_s[i+1] <= (5'(i) < exp_n_s[i]) ? ep[60:30] : exp_e_s[i];
				exp_den_s[i+1] <= exp_den_s[i];
				exp_neg_s[i+1] <= exp_neg_s[i];
				exp_meta_s[i+1] <= exp_meta_s[i];
			end
		end

		if (i < ES - 1) begin : g_count
			always_ff @(posedge clk) begin
				if (en) begin
					exp_n_s[i+1] <= exp_n_s[i];
				end
			end
		end
	end

	logic v_d2;
	logic [31:0] quo2;
	ncdf_pkg::ncdf_tag_t tag_d2;

	ncdf_div u_div_recip (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(exp_v_s[ES]),
		.num(64'h1000_0000_0000_0000),
		.den({1'b0, exp_den_s[ES]}),
		.tag_in('{meta: exp_meta_s[ES], neg: exp_neg_s[ES], ovf: 1'b0, e: exp_e_s[ES]}),
		.out_valid(v_d2),
		.quo(quo2),
		.tag_out(tag_d2)
	);

	// Horner evaluation of the erf polynomial in t.
	logic hv_s [0:HS];
	logic signed [33:0] h_s [0:HS];
	logic [30:0] t_s [0:HS-1];
	ncdf_pkg::ncdf_tag_t htag_s [0:HS];

	assign hv_s[0] = v_d2;
	assign h_s[0] = ncdf_pkg::CA5;
	assign t_s[0] = quo2[30:0];
	assign htag_s[0] = tag_d2;

	for (genvar k = 0; k < HS; k++) begin : g_horner
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_s[k+1] <= 1'b0;
			end else if (en) begin
				hv_s[k+1] <= hv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				h_s[k+1] <= mulq(h_s[k], t_s[k]) + ncdf_pkg::HORNER_C[k];
				htag_s[k+1] <= htag_s[k];
			end
		end

		if (k < HS - 1) begin : g_t
			always_ff @(posedge clk) begin
				if (en) begin
					t_s[k+1] <= t_s[k];
				end
			end
		end
	end

	// Stage after Horner: y = 1 - h * exp(-w).
	logic [32:0] hpos;
	logic [63:0] hprod;
	logic [33:0] prod;
	logic v_s8;
	ncdf_pkg::ncdf_tag_t tag_s8;
	logic [30:0] y_s8;

	assign hpos = h_s[HS][33] ? 33'd0 : h_s[HS][32:0];
	assign hprod = 64'(hpos) * 64'(htag_s[HS].e);
	assign prod = hprod[63:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= hv_s[HS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s8 <= htag_s[HS];
			y_s8 <= (prod >= 34'h0_4000_0000) ? 31'd0 : 31'(34'h0_4000_0000 - prod);
		end
	end

	// Output stage: round to Q1.16, fold p-values, select the fallback.
	logic [31:0] cval;
	logic [32:0] csum;
	logic [17:0] rnd;
	logic [16:0] pcl;
	logic [16:0] dev;
	logic [16:0] pout;
	logic valid_s9;
	ncdf_pkg::ncdf_meta_t meta_s9;
	logic [16:0] prob_s9;
	logic fb_s9;

	always_comb begin
		cval = tag_s8.neg ? 32'h4000_0000 - 32'(y_s8) : 32'h4000_0000 + 32'(y_s8);
		csum = 33'(cval) + 33'h0_0000_4000;
		rnd = csum[32:15];
		pcl = (rnd > 18'(ncdf_pkg::P_ONE)) ? ncdf_pkg::P_ONE : rnd[16:0];
		dev = (pcl >= ncdf_pkg::P_HALF) ? pcl - ncdf_pkg::P_HALF : ncdf_pkg::P_HALF - pcl;
		pout = tag_s8.meta.mode[1] ? ncdf_pkg::P_HALF - dev : pcl;
		if (tag_s8.meta.fb) begin
			pout = tag_s8.meta.fbp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s9 <= tag_s8.meta;
			prob_s9 <= pout;
			fb_s9 <= tag_s8.meta.fb;
		end
	end

	assign result.valid = valid_s9;
	assign result.probability = prob_s9;
	assign result.fallback_used = fb_s9;

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> v_s1)
		else $error("Accepted sample did not enter the first stage.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.probability <= ncdf_pkg::P_ONE)
		else $error("Probability above one.");

	a_fold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.fallback_used && meta_s9.mode[1]
		|-> result.probability <= ncdf_pkg::P_HALF)
		else $error("Folded p-value above one half.");

	a_fallback_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.fallback_used |-> meta_s9.mode[1])
		else $error("Fallback raised outside the p-value modes.");

endmodule

[bench/normal_cdf_pvalue_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench of the normal CDF and p-value unit, checked against a local predictor.
module normal_cdf_pvalue_unit_tb;

	localparam int PIPE_LATENCY = 99;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint ONE30 = 64'sd1073741824;

	typedef struct packed {
		logic [16:0] probability;
		logic fallback_used;
	} prob_result_t;

	logic clk;
	logic arst_n;

	ncdf_sample_if sample();
	ncdf_result_if result();
	ncdf_cfg_if cfg();

	normal_cdf_pvalue_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample.sink),
		.result(result.source),
		.cfg(cfg.sink)
	);

	prob_result_t expected_probs[$];
	longint unsigned exp_lut [ncdf_pkg::EXP_SIZE];
	ncdf_pkg::ncdf_mode_t cur_mode;
	logic [16:0] cur_default;
	int error_count;
	int idle_cycles;
	bit stall_enable;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint scale_q30(longint a, longint unsigned t);
		longint unsigned m;
		longint unsigned r;
		m = (a < 0) ? longint'(-a) : a;
		r = (m * t) >> 30;
		return (a < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint unsigned exp_entry(int k);
		longint unsigned f;
		longint unsigned term;
		longint acc;
		f = longint'(k) << (30 - ncdf_pkg::EXP_TABLE_BITS);
		term = 64'd1 << 30;
		acc = ONE30;
		for (int n = 1; n <= 16; n++) begin
			term = ((term * f) >> 30) / longint'(n);
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		return (acc < 0) ? 0 : acc;
	endfunction

	function automatic longint std_normal_cdf(longint z);
		bit neg;
		longint unsigned mag, u, den, t, w, n, e, prod, c;
		longint h, y;
		neg = z < 0;
		mag = neg ? longint'(-z) : z;
		u = (mag * 64'd759250125) >> 30;
		if (u > 64'd524288) begin
			u = 64'd524288;
		end
		den = 64'd1073741824 + ((64'd351748265 * u) >> 16);
		t = (64'd1 << 60) / den;
		h = 64'sd1139675401;
		h = scale_q30(h, t) - 64'sd1560310108;
		h = scale_q30(h, t) + 64'sd1526231383;
		h = scale_q30(h, t) - 64'sd305476044;
		h = scale_q30(h, t) + 64'sd273621191;
		h = scale_q30(h, t);
		if (h < 0) begin
			h = 0;
		end
		w = (u * u) >> 16;
		n = w >> 16;
		e = exp_lut[(w & 64'hFFFF) >> (16 - ncdf_pkg::EXP_TABLE_BITS)];
		for (longint unsigned i = 0; i < n && e != 0; i++) begin
			e = (e * 64'd395007542) >> 30;
		end
		prod = (longint'(h) * e) >> 30;
		y = ONE30 - longint'(prod);
		if (y < 0) begin
			y = 0;
		end
		c = neg ? (ONE30 - y) : (ONE30 + y);
		c = (c + (64'd1 << 14)) >> 15;
		if (c > 65536) begin
			c = 65536;
		end
		return c;
	endfunction

	function automatic prob_result_t predict_probability(logic signed [31:0] vx,
			logic signed [31:0] va, logic signed [31:0] vb);
		prob_result_t res;
		longint x, a, b, z, p, d, s, dev;
		x = vx;
		a = va;
		b = vb;
		res.fallback_used = 1'b0;
		if (cur_mode == ncdf_pkg::MODE_STD) begin
			z = x;
		end else if (cur_mode == ncdf_pkg::MODE_SCALED) begin
			s = (b == 0) ? 64'sd65536 : b;
			z = clamp32(((x - a) * 64'sd65536) / s);
		end else begin
			d = b - a;
			if (d <= 0) begin
				res.probability = (cur_default > 17'd65536) ? 17'd65536 : cur_default;
				res.fallback_used = 1'b1;
				return res;
			end
			if (cur_mode == ncdf_pkg::MODE_ONE_SIDED) begin
				z = clamp32((x * 64'sd128451) / d);
			end else begin
				z = clamp32(((x - a) * 64'sd256902) / d - 64'sd128451);
			end
		end
		p = std_normal_cdf(z);
		if (cur_mode == ncdf_pkg::MODE_ONE_SIDED || cur_mode == ncdf_pkg::MODE_TWO_SIDED) begin
			dev = 64'sd32768 - p;
			if (dev < 0) begin
				dev = -dev;
			end
			p = 64'sd32768 - dev;
		end
		res.probability = p[16:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		$display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	task automatic write_register(ncdf_pkg::ncdf_reg_t idx, logic [16:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) begin
			@(posedge clk);
		end
		cfg.valid <= 1'b0;
		if (idx == ncdf_pkg::REG_MODE) begin
			cur_mode = ncdf_pkg::ncdf_mode_t'(value[1:0]);
		end else begin
			cur_default = value;
		end
		@(posedge clk);
	endtask

	task automatic send_sample(logic signed [31:0] vx, logic signed [31:0] va,
			logic signed [31:0] vb, bit with_gap);
		int gap;
		gap = with_gap ? gap_length() : 0;
		if (gap > 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.value_x <= vx;
		sample.lower_or_mean <= va;
		sample.upper_or_sigma <= vb;
		@(posedge clk);
		while (!sample.ready) begin
			@(posedge clk);
		end
		expected_probs.push_back(predict_probability(vx, va, vb));
	endtask

	task automatic drain_pipeline();
		sample.valid <= 1'b0;
		while (expected_probs.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic signed [31:0] random_word();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $signed(32'($urandom_range(0, 6 << 16))) - (3 << 16);
			2: return $signed(32'($urandom_range(0, 1 << 16))) - (1 << 15);
			3: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $signed(32'($urandom_range(0, 20 << 16))) - (10 << 16);
		endcase
	endfunction

	task automatic test_extremes();
		logic signed [31:0] edges [6];
		edges = '{32'sh80000000, 32'sh7FFFFFFF, 32'sd0, -32'sd1, 32'sd65536, -32'sd65536};
		write_register(ncdf_pkg::REG_MODE, ncdf_pkg::MODE_STD);
		foreach (edges[i]) begin
			send_sample(edges[i], 32'sd0, 32'sd0, 1'b0);
		end
		drain_pipeline();
	endtask

	task automatic test_modes_directed();
		write_register(ncdf_pkg::REG_MODE, ncdf_pkg::MODE_SCALED);
		send_sample(32'sd65536, 32'sd0, 32'sd0, 1'b0);
		send_sample(32'sh7FFFFFFF, 32'sh80000000, 32'sd1, 1'b0);
		send_sample(32'sd131072, 32'sd65536, -32'sd65536, 1'b0);
		drain_pipeline();
		write_register(ncdf_pkg::REG_DEFAULT, 17'h1FFFF);
		write_register(ncdf_pkg::REG_MODE, ncdf_pkg::MODE_ONE_SIDED);
		send_sample(32'sd65536, 32'sd0, 32'sd65536, 1'b0);
		send_sample(32'sd65536, 32'sd65536, 32'sd65536, 1'b0);
		send_sample(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
		send_sample(-32'sd65536, 32'sd0, 32'sd1, 1'b0);
		drain_pipeline();
		write_register(ncdf_pkg::REG_DEFAULT, 17'd0);
		write_register(ncdf_pkg::REG_MODE, ncdf_pkg::MODE_TWO_SIDED);
		send_sample(32'sd0, 32'sd0, 32'sd65536, 1'b0);
		send_sample(32'sd65536, 32'sd0, 32'sd65536, 1'b0);
		send_sample(32'sd0, 32'sd65536, 32'sd0, 1'b0);
		send_sample(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b0);
		send_sample(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
		drain_pipeline();
	endtask

	task automatic test_random_mixed();
		logic signed [31:0] vx, va, vb;
		for (int phase = 0; phase < 8; phase++) begin
			write_register(ncdf_pkg::REG_MODE, ncdf_pkg::ncdf_mode_t'(phase % 4));
			write_register(ncdf_pkg::REG_DEFAULT, (phase == 5) ? 17'd65536 : 17'($urandom));
			stall_enable = (phase != 3);
			for (int i = 0; i < 130; i++) begin
				vx = random_word();
				va = random_word();
				vb = random_word();
				if (cur_mode >= ncdf_pkg::MODE_ONE_SIDED && $urandom_range(0, 9) < 8
						&& va > vb) begin
					{va, vb} = {vb, va};
				end
				send_sample(vx, va, vb, stall_enable);
			end
			drain_pipeline();
		end
		stall_enable = 1'b1;
	endtask

	initial begin
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!stall_enable || $urandom_range(0, 3) != 0) begin
				result.ready <= 1'b1;
			end else begin
				result.ready <= 1'b0;
				repeat (gap_length() + 1) @(posedge clk);
				result.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		prob_result_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_probs.size() == 0) begin
				report_mismatch("unexpected beat, probability", result.probability, -1);
			end else begin
				want = expected_probs.pop_front();
				if (result.probability !== want.probability) begin
					report_mismatch("probability", result.probability, want.probability);
				end
				if (result.fallback_used !== want.fallback_used) begin
					report_mismatch("fallback_used", result.fallback_used, want.fallback_used);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("normal_cdf_pvalue_unit test failed");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < ncdf_pkg::EXP_SIZE; k++) begin
			exp_lut[k] = exp_entry(k);
		end
		error_count = 0;
		idle_cycles = 0;
		stall_enable = 1'b1;
		cur_mode = ncdf_pkg::MODE_TWO_SIDED;
		cur_default = 17'd65536;
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.value_x = '0;
		sample.lower_or_mean = '0;
		sample.upper_or_sigma = '0;
		cfg.valid = 1'b0;
		cfg.index = ncdf_pkg::REG_MODE;
		cfg.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_sample(32'sd0, 32'sd0, 32'sd65536, 1'b0);
		send_sample(32'sd0, 32'sd65536, 32'sd0, 1'b0);
		drain_pipeline();
		test_extremes();
		test_modes_directed();
		test_random_mixed();
		drain_pipeline();
		if (error_count == 0) begin
			$display("normal_cdf_pvalue_unit test passed");
		end else begin
			$display("normal_cdf_pvalue_unit test failed");
		end
		$finish;
	end
endmodule
